### design/tor_pkg.sv
// ----------------------------------------------------------------------------
// tor_pkg: shared types and codes of the telnet option receiver
// Telnet command codes, parser phase and verb types, the result word layout
// and the sizing of the output queue.
// ----------------------------------------------------------------------------
package tor_pkg;

   // Telnet command codes
   localparam logic [7:0] CODE_IAC  = 8'd255;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_WONT = 8'd252;
   localparam logic [7:0] CODE_DO   = 8'd253;
   localparam logic [7:0] CODE_DONT = 8'd254;

   // Option codes that the receiver agrees to on WILL
   localparam logic [7:0] OPT_BINARY = 8'd0;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;

   // Default number of tracked options
   localparam int OPTION_COUNT_DEF = 4;

   // Result words per input item, at most
   localparam int MAX_WORDS = 3;

   // Output queue sizing
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Output channel codes
   localparam logic CHAN_DATA = 1'b0;
   localparam logic CHAN_PEER = 1'b1;

   // Parser phase of the received byte stream
   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_IAC   = 2'd1,
      PH_VERB  = 2'd2
   } phase_type;

   // Negotiation verb, coded as verb - WILL
   typedef enum logic [1:0] {
      VB_WILL = 2'd0,
      VB_WONT = 2'd1,
      VB_DO   = 2'd2,
      VB_DONT = 2'd3
   } verb_type;

   // One result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_channel;
      logic       last;
   } word_type;

   // Option flag update from the decoder
   typedef struct packed {
      logic remote_we;
      logic local_we;
      logic value;
   } flag_wr_type;

   // Output queue status toward the top level
   typedef struct packed {
      logic                   room;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_stat_type;

endpackage

### design/tor_flags.sv
// ----------------------------------------------------------------------------
// tor_flags: remote and local option flags
// One flag per option for each side, cleared by reset, read and written at
// the option index of the word in the decode stage.
// ----------------------------------------------------------------------------
module tor_flags
   import tor_pkg::*;
#(
   parameter int OPTION_COUNT = OPTION_COUNT_DEF,
   localparam int IDX_W = $clog2(OPTION_COUNT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] index,
   input  flag_wr_type      wr,
   output logic             remote_rd,
   output logic             local_rd
);

   logic [OPTION_COUNT-1:0] remote_ff, remote_in;
   logic [OPTION_COUNT-1:0] local_ff, local_in;
   logic                    in_rng;

   // Index may exceed the table when the count is not a power of two
   assign in_rng    = int'(index) < OPTION_COUNT;
   assign remote_rd = in_rng ? remote_ff[index] : 1'b0;
   assign local_rd  = in_rng ? local_ff[index] : 1'b0;

   // Apply flag updates
   always_comb begin
      remote_in = remote_ff;
      local_in  = local_ff;
      if (wr.remote_we && in_rng) begin
         remote_in[index] = wr.value;
      end
      if (wr.local_we && in_rng) begin
         local_in[index] = wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remote_ff <= '0;
         local_ff  <= '0;
      end else begin
         remote_ff <= remote_in;
         local_ff  <= local_in;
      end
   end

endmodule

### design/tor_decode.sv
// ----------------------------------------------------------------------------
// tor_decode: telnet parser and option negotiation logic
// Computes the next parser phase, option flag updates and up to three
// result words for the word held in the input register.
// ----------------------------------------------------------------------------
module tor_decode
   import tor_pkg::*;
#(
   parameter int OPTION_COUNT = OPTION_COUNT_DEF
) (
   input  logic                            func,
   input  logic [7:0]                      rx_byte,
   input  logic [7:0]                      request_command,
   input  logic [7:0]                      request_option,
   input  phase_type                       phase,
   input  verb_type                        verb,
   input  logic                            remote_rd,
   input  logic                            local_rd,
   output phase_type                       phase_next,
   output verb_type                        verb_next,
   output flag_wr_type                     wr,
   output logic [1:0]                      count,
   output word_type [MAX_WORDS-1:0]        words
);

   localparam logic [8:0] OPT_LIMIT = 9'(OPTION_COUNT);

   logic [7:0] opt;
   logic       in_range;
   logic       rx_is_verb;
   logic       req_is_verb;
   logic       supported;

   // Build IAC verb option for the peer
   function automatic word_type [MAX_WORDS-1:0] reply(input logic [7:0] vb,
                                                     input logic [7:0] op);
      word_type [MAX_WORDS-1:0] w;
      w[0] = '{out_byte: CODE_IAC, out_channel: CHAN_PEER, last: 1'b0};
      w[1] = '{out_byte: vb,       out_channel: CHAN_PEER, last: 1'b0};
      w[2] = '{out_byte: op,       out_channel: CHAN_PEER, last: 1'b1};
      return w;
   endfunction

   assign opt         = func ? request_option : rx_byte;
   assign in_range    = {1'b0, opt} < OPT_LIMIT;
   assign rx_is_verb  = (rx_byte >= CODE_WILL) && (rx_byte <= CODE_DONT);
   assign req_is_verb = (request_command >= CODE_WILL) && (request_command <= CODE_DONT);
   assign supported   = in_range &&
                        (rx_byte == OPT_BINARY || rx_byte == OPT_ECHO || rx_byte == OPT_SGA);

   // Next parser phase; local requests leave it alone
   always_comb begin
      phase_next = phase;
      verb_next  = verb;
      if (!func) begin
         unique case (phase)
            PH_IAC: begin
               if (rx_is_verb) begin
                  verb_next  = verb_type'(rx_byte[1:0] + 2'd1);
                  phase_next = PH_VERB;
               end else begin
                  phase_next = PH_PLAIN;
               end
            end
            PH_VERB: begin
               phase_next = PH_PLAIN;
            end
            default: begin
               phase_next = (rx_byte == CODE_IAC) ? PH_IAC : PH_PLAIN;
            end
         endcase
      end
   end

   // Result words and flag updates
   always_comb begin
      wr    = '0;
      count = 2'd0;
      words = '0;
      if (func) begin
         // Local request: set the flag, send the request
         if (req_is_verb && in_range) begin
            if (request_command == CODE_DO || request_command == CODE_DONT) begin
               wr.remote_we = 1'b1;
            end else begin
               wr.local_we = 1'b1;
            end
            wr.value = 1'b1;
            words    = reply(request_command, request_option);
            count    = 2'd3;
         end
      end else begin
         unique case (phase)
            PH_IAC: begin
               // Doubled IAC stands for one data byte
               if (rx_byte == CODE_IAC) begin
                  words[0] = '{out_byte: CODE_IAC, out_channel: CHAN_DATA, last: 1'b1};
                  count    = 2'd1;
               end
            end
            PH_VERB: begin
               unique case (verb)
                  VB_WILL: begin
                     if (supported) begin
                        if (!remote_rd) begin
                           wr    = '{remote_we: 1'b1, local_we: 1'b0, value: 1'b1};
                           words = reply(CODE_DO, rx_byte);
                           count = 2'd3;
                        end
                     end else begin
                        words = reply(CODE_DONT, rx_byte);
                        count = 2'd3;
                     end
                  end
                  VB_WONT: begin
                     if (!in_range || remote_rd) begin
                        wr.remote_we = in_range;
                        words        = reply(CODE_DONT, rx_byte);
                        count        = 2'd3;
                     end
                  end
                  VB_DO: begin
                     words = reply(CODE_WONT, rx_byte);
                     count = 2'd3;
                  end
                  VB_DONT: begin
                     if (!in_range || local_rd) begin
                        wr.local_we = in_range;
                        words       = reply(CODE_WONT, rx_byte);
                        count       = 2'd3;
                     end
                  end
               endcase
            end
            default: begin
               // Plain data passes through; IAC opens a command
               if (rx_byte != CODE_IAC) begin
                  words[0] = '{out_byte: rx_byte, out_channel: CHAN_DATA, last: 1'b1};
                  count    = 2'd1;
               end
            end
         endcase
      end
   end

endmodule

### design/tor_queue.sv
// ----------------------------------------------------------------------------
// tor_queue: output word queue
// Takes up to three words in one cycle and hands out one word per cycle on
// the result channel while that side takes words.
// ----------------------------------------------------------------------------
module tor_queue
   import tor_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_cnt,
   input  word_type [MAX_WORDS-1:0] push_words,
   input  logic                     pop,
   output word_type                 head,
   output queue_stat_type           stat
);

   word_type               mem_ff [QUEUE_DEPTH];
   word_type               mem_in [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.room  = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_WORDS);

   // Write the new words behind the tail, advance pointers
   always_comb begin
      logic [QUEUE_PTR_W-1:0] slot;
      mem_in = mem_ff;
      for (int i = 0; i < MAX_WORDS; i++) begin
         slot = wr_ptr_ff + QUEUE_PTR_W'(i);
         if (i < int'(push_cnt)) begin
            mem_in[slot] = push_words[i];
         end
      end
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push_cnt) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/telnet_option_receiver.sv
// ----------------------------------------------------------------------------
// telnet_option_receiver: telnet receive filter with option negotiation
// Passes data bytes to the terminal side, strips IAC sequences, answers
// option negotiation and sends local negotiation requests to the peer.
//
//   channel  direction  handshake          payload
//   req_     in         tvalid / tready    tdata, tuser = func, tlast = chunk end
//   rsp_     out        tvalid / tready    tdata, tuser = channel, tlast = last
//
// A word is taken into the input register in any cycle it is free or drains.
// Decode is combinational; results go into an 8-word output queue.
// Data bytes flow at one word per cycle while the result side takes words;
// a negotiation reply is three output words, so replies are paced by the queue.
// Reset clears the parser, all option flags and the queue at once.
// A stalled result side leaves the queue short of room, then req_tready drops.
// ----------------------------------------------------------------------------
module telnet_option_receiver
   import tor_pkg::*;
#(
   parameter int OPTION_COUNT = OPTION_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] rx_byte, [15:8] request_command, [23:16] request_option
   input  logic [23:0] req_tdata,
   // [0] func
   input  logic        req_tuser,
   // chunk end, carries no meaning here
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   // [0] out_channel
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(OPTION_COUNT);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_func_ff, in_func_in;
   logic [7:0]               in_byte_ff, in_byte_in;
   logic [7:0]               in_cmd_ff, in_cmd_in;
   logic [7:0]               in_opt_ff, in_opt_in;
   phase_type                phase_ff, phase_in;
   verb_type                 verb_ff, verb_in;
   phase_type                phase_next;
   verb_type                 verb_next;
   flag_wr_type              dec_wr;
   flag_wr_type              flag_wr;
   logic [1:0]               dec_count;
   logic [1:0]               push_cnt;
   word_type [MAX_WORDS-1:0] dec_words;
   logic                     remote_rd;
   logic                     local_rd;
   logic [IDX_W-1:0]         flag_idx;
   logic                     req_take;
   logic                     advance;
   logic                     pop;
   word_type                 head;
   queue_stat_type           qstat;

   // Input handshake and decode advance
   assign advance    = in_valid_ff && qstat.room;
   assign req_tready = !in_valid_ff || qstat.room;
   assign req_take   = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // Load the input register, hold otherwise
   always_comb begin
      in_valid_in = in_valid_ff;
      in_func_in  = in_func_ff;
      in_byte_in  = in_byte_ff;
      in_cmd_in   = in_cmd_ff;
      in_opt_in   = in_opt_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_func_in  = req_tuser;
         in_byte_in  = req_tdata[7:0];
         in_cmd_in   = req_tdata[15:8];
         in_opt_in   = req_tdata[23:16];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Commit parser state when the word advances
   always_comb begin
      phase_in = advance ? phase_next : phase_ff;
      verb_in  = advance ? verb_next : verb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_PLAIN;
         verb_ff     <= VB_WILL;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         verb_ff     <= verb_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff <= in_func_in;
      in_byte_ff <= in_byte_in;
      in_cmd_ff  <= in_cmd_in;
      in_opt_ff  <= in_opt_in;
   end

   // Option index of the word in decode
   assign flag_idx = in_func_ff ? in_opt_ff[IDX_W-1:0] : in_byte_ff[IDX_W-1:0];
   assign flag_wr  = advance ? dec_wr : '0;
   assign push_cnt = advance ? dec_count : 2'd0;

   tor_flags #(
      .OPTION_COUNT(OPTION_COUNT)
   ) u_flags (
      .clock    (clock),
      .reset    (reset),
      .index    (flag_idx),
      .wr       (flag_wr),
      .remote_rd(remote_rd),
      .local_rd (local_rd)
   );

   tor_decode #(
      .OPTION_COUNT(OPTION_COUNT)
   ) u_decode (
      .func           (in_func_ff),
      .rx_byte        (in_byte_ff),
      .request_command(in_cmd_ff),
      .request_option (in_opt_ff),
      .phase          (phase_ff),
      .verb           (verb_ff),
      .remote_rd      (remote_rd),
      .local_rd       (local_rd),
      .phase_next     (phase_next),
      .verb_next      (verb_next),
      .wr             (dec_wr),
      .count          (dec_count),
      .words          (dec_words)
   );

   tor_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_words(dec_words),
      .pop       (pop),
      .head      (head),
      .stat      (qstat)
   );

   // Drive the result channel from the queue head
   assign rsp_tvalid = qstat.count != '0;
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = head.out_channel;
   assign rsp_tlast  = head.last;

   // Queue never holds more words than it has entries
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("output queue overflow");

   // A word that finishes a command returns the parser to plain data
   a_verb_done: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_func_ff && phase_ff == PH_VERB) |=> (phase_ff == PH_PLAIN))
      else $error("parser did not return to plain data");

   // Local requests leave the parser phase untouched
   a_req_phase: assert property (@(posedge clock) disable iff (reset)
      (advance && in_func_ff) |=> $stable(phase_ff))
      else $error("local request changed parser phase");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

### sim/telnet_rx_checker.sv
// ----------------------------------------------------------------------------
// telnet_rx_checker: scoreboard for the telnet option receiver
// Watches both stream channels. Every word taken on the request side is run
// through a local model of the telnet filter (parser phase, pending verb,
// remote and local option flags), and the words that it owes are queued.
// Every word delivered on the result side is compared field by field with
// the oldest owed word.
// ----------------------------------------------------------------------------
module telnet_rx_checker
   import tor_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [7:0] rx_byte, [15:8] request_command, [23:16] request_option
   input  logic [23:0] req_tdata,
   // [0] func
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   input  logic [7:0]  rsp_tdata,
   // [0] out_channel
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          owed_total
);

   localparam int NOPT = OPTION_COUNT_DEF;

   // model state
   phase_type  phase;
   verb_type   verb;
   logic       remote_on [NOPT];
   logic       local_on  [NOPT];

   // words the block still owes, oldest first
   word_type   owed_words [$];
   int         mismatches = 0;

   assign fail_count = mismatches;

   function automatic void owe_word(logic [7:0] b, logic chan, logic fin);
      word_type w;
      w.out_byte    = b;
      w.out_channel = chan;
      w.last        = fin;
      owed_words.push_back(w);
   endfunction

   // three-word negotiation message toward the peer
   function automatic void owe_reply(logic [7:0] vcode, logic [7:0] opt);
      owe_word(CODE_IAC, CHAN_PEER, 1'b0);
      owe_word(vcode, CHAN_PEER, 1'b0);
      owe_word(opt, CHAN_PEER, 1'b1);
   endfunction

   // answer IAC verb option from the peer
   function automatic void negotiate(logic [7:0] opt);
      logic in_range;
      in_range = (opt < NOPT);
      case (verb)
         VB_WILL: begin
            if (in_range && (opt == OPT_BINARY || opt == OPT_ECHO || opt == OPT_SGA)) begin
               if (!remote_on[opt]) begin
                  remote_on[opt] = 1'b1;
                  owe_reply(CODE_DO, opt);
               end
            end else begin
               owe_reply(CODE_DONT, opt);
            end
         end
         VB_WONT: begin
            if (!in_range) begin
               owe_reply(CODE_DONT, opt);
            end else if (remote_on[opt]) begin
               remote_on[opt] = 1'b0;
               owe_reply(CODE_DONT, opt);
            end
         end
         VB_DO: begin
            owe_reply(CODE_WONT, opt);
         end
         default: begin
            if (!in_range) begin
               owe_reply(CODE_WONT, opt);
            end else if (local_on[opt]) begin
               local_on[opt] = 1'b0;
               owe_reply(CODE_WONT, opt);
            end
         end
      endcase
   endfunction

   // advance the model by one request word
   function automatic void filter_word(logic func, logic [7:0] rx, logic [7:0] cmd,
                                       logic [7:0] opt);
      logic [7:0] vdiff;
      if (func) begin
         // local request: parse phase stays as it is
         if (cmd >= CODE_WILL && cmd <= CODE_DONT && opt < NOPT) begin
            if (cmd == CODE_DO || cmd == CODE_DONT) begin
               remote_on[opt] = 1'b1;
            end else begin
               local_on[opt] = 1'b1;
            end
            owe_reply(cmd, opt);
         end
      end else begin
         case (phase)
            PH_IAC: begin
               if (rx >= CODE_WILL && rx <= CODE_DONT) begin
                  vdiff = rx - CODE_WILL;
                  verb  = verb_type'(vdiff[1:0]);
                  phase = PH_VERB;
               end else begin
                  phase = PH_PLAIN;
                  if (rx == CODE_IAC) begin
                     owe_word(CODE_IAC, CHAN_DATA, 1'b1);
                  end
               end
            end
            PH_VERB: begin
               phase = PH_PLAIN;
               negotiate(rx);
            end
            default: begin
               // plain data, and the unused phase code too
               if (rx == CODE_IAC) begin
                  phase = PH_IAC;
               end else begin
                  phase = PH_PLAIN;
                  owe_word(rx, CHAN_DATA, 1'b1);
               end
            end
         endcase
      end
   endfunction

   // compare delivered words, then take in new request words
   always @(posedge clock) begin : watch
      word_type want;
      if (reset) begin
         phase = PH_PLAIN;
         verb  = VB_WILL;
         for (int i = 0; i < NOPT; i++) begin
            remote_on[i] = 1'b0;
            local_on[i]  = 1'b0;
         end
         owed_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_words.size() == 0) begin
               $error("unexpected word: out_byte %0d out_channel %0d last %0d",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = owed_words.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.out_channel) begin
                  $error("out_channel: expected %0d, got %0d", want.out_channel, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            filter_word(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         end
      end
      owed_total <= owed_words.size();
   end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the telnet option receiver
// Drives a short directed sequence (data bytes, doubled IAC, dropped IAC
// commands, each negotiation verb, local requests, a local request inside a
// pending sequence), then random sequences, mostly well formed. Both sides
// idle at random, and the result side holds off once for a long stretch.
// The checker does the comparing; this module reports the outcome.
// ----------------------------------------------------------------------------
module tb;
   import tor_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_WORDS = 450;
   localparam int HOLD_AFTER   = 200;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int          fail_count;
   int          owed_total;
   int          sent  = 0;
   bit          quiet = 0;

   telnet_option_receiver u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   telnet_rx_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .owed_total (owed_total)
   );

   // clock and reset
   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // mostly short gaps, a few long ones, none while quiet
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one word after a random gap and wait for it to be taken
   task automatic send_word(input logic func, input logic [7:0] rx, input logic [7:0] cmd,
                            input logic [7:0] opt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {opt, cmd, rx};
      req_tlast  <= 1'($urandom_range(0, 1));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (sent % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_rx(input logic [7:0] b);
      send_word(1'b0, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic send_local(input logic [7:0] cmd, input logic [7:0] opt);
      send_word(1'b1, 8'($urandom_range(0, 255)), cmd, opt);
   endtask

   // mostly tracked options, some just past them, some anywhere
   function automatic logic [7:0] pick_option();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'($urandom_range(0, 3));
      if (r < 8) return 8'($urandom_range(4, 7));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_verb();
      return 8'($urandom_range(CODE_WILL, CODE_DONT));
   endfunction

   // stimulus
   initial begin : stimulus
      int pick;
      int goal;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      do @(posedge clock); while (reset);

      // verb code as a plain byte passes through
      send_rx(CODE_WILL);
      // doubled IAC, then IAC with a non-verb byte
      send_rx(CODE_IAC); send_rx(CODE_IAC);
      send_rx(CODE_IAC); send_rx(8'h41);
      // WILL on a supported option, then on an unsupported one
      send_rx(CODE_IAC); send_rx(CODE_WILL); send_rx(OPT_BINARY);
      send_rx(CODE_IAC); send_rx(CODE_WILL); send_rx(8'd2);
      // WONT on an option that is on
      send_rx(CODE_IAC); send_rx(CODE_WONT); send_rx(OPT_BINARY);
      // local WILL, then the peer turns it off with DONT
      send_local(CODE_WILL, OPT_ECHO);
      send_rx(CODE_IAC); send_rx(CODE_DONT); send_rx(OPT_ECHO);
      // DO on the highest option code
      send_rx(CODE_IAC); send_rx(CODE_DO); send_rx(8'hff);
      // local requests that do nothing: bad verb, option out of range
      send_local(8'd250, 8'd0);
      send_local(CODE_DO, 8'd4);
      // local DONT in the middle of a sequence, then WONT on that option
      send_rx(CODE_IAC);
      send_local(CODE_DONT, OPT_SGA);
      send_rx(CODE_WONT); send_rx(OPT_SGA);

      // random sequences, mostly well formed
      goal = sent + RANDOM_WORDS;
      while (sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_rx(8'($urandom_range(0, 254)));
         end else if (pick < 38) begin
            send_rx(CODE_IAC); send_rx(CODE_IAC);
         end else if (pick < 73) begin
            send_rx(CODE_IAC); send_rx(pick_verb()); send_rx(pick_option());
         end else if (pick < 78) begin
            send_rx(CODE_IAC); send_rx(8'($urandom_range(0, 250)));
         end else if (pick < 93) begin
            send_local(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : pick_verb(),
                       pick_option());
         end else begin
            send_rx(8'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;

      // drain, then give the block time to show anything extra
      @(posedge clock);
      while (owed_total != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && owed_total == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off
   initial begin : receiver
      int stall;
      bit held;
      rsp_tready = 1'b0;
      stall      = 0;
      held       = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (!held && sent >= HOLD_AFTER) begin
            held = 1;
            rsp_tready <= 1'b0;
            stall = LONG_HOLD - 1;
         end else begin
            stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               stall--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
         @(posedge clock);
      end
   end

   // watchdog: end the run when nothing moves for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
design/tor_pkg.sv
design/tor_flags.sv
design/tor_decode.sv
design/tor_queue.sv
design/telnet_option_receiver.sv
sim/telnet_rx_checker.sv
sim/tb.sv
